>>> hw/rtl/chf_pkg.sv
// shared constants and elaboration-time functions for the compass heading block
package chf_pkg;

  localparam int unsigned FieldW     = 16;
  localparam int unsigned PrescaleW  = 16;
  localparam int unsigned XyW        = 35;
  localparam int unsigned DeclW      = 15;
  localparam int unsigned HeadW      = 9;
  localparam int unsigned DeclQuoW   = 11;
  localparam int unsigned RecipW     = 16;
  localparam int unsigned RecipShift = 19;
  localparam int unsigned ProdW      = DeclW + RecipW;

  localparam logic signed [DeclW-1:0] DeclReset = 15'sd266;
  localparam logic [RecipW-1:0]       Recip15   = 16'd34953;
  localparam logic [HeadW-1:0]        HeadMax   = 9'd360;
  localparam longint                  RadToDegQ32 = 64'sd246083499207;

  // shift-subtract division, elaboration only
  function automatic longint unsigned udiv(input longint unsigned num,
                                           input longint unsigned den);
    longint unsigned rem;
    longint unsigned quo;
    rem = '0;
    quo = '0;
    for (int k = 63; k >= 0; k--) begin
      rem = {rem[62:0], num[k]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[k] = 1'b1;
      end
    end
    return quo;
  endfunction

  // atan(2^-i) in degrees with frac fractional bits, rounded half up
  function automatic longint atan_deg(input int unsigned i, input int unsigned frac);
    longint      q32;
    longint      rad;
    longint      term;
    longint      hi;
    longint      lo;
    int unsigned e;
    rad = 0;
    if (i == 0) begin
      q32 = longint'(45) <<< 32;
    end else begin
      for (int unsigned n = 0; n < 64; n++) begin
        e = i * (2 * n + 1);
        if (e <= 40) begin
          term = longint'(udiv(longint'(1) << (40 - e), longint'(2 * n + 1)));
          if (n[0]) begin
            rad = rad - term;
          end else begin
            rad = rad + term;
          end
        end
      end
      hi  = rad >>> 20;
      lo  = rad & longint'(20'hFFFFF);
      q32 = (hi * RadToDegQ32 + ((lo * RadToDegQ32) >>> 20)) >>> 20;
    end
    return (q32 + (longint'(1) << (31 - frac))) >>> (32 - frac);
  endfunction

endpackage

>>> hw/rtl/chf_cell.sv
// one vectoring rotation cell of the heading chain
module chf_cell #(
  parameter int unsigned              ANG_W = 28,
  parameter int unsigned              STAGE = 0,
  parameter logic signed [ANG_W-1:0]  ATAN  = '0
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             valid_i,
  output logic                             ready_o,
  input  logic signed [chf_pkg::XyW-1:0]   a_i,
  input  logic signed [chf_pkg::XyW-1:0]   b_i,
  input  logic signed [ANG_W-1:0]          ang_i,
  input  logic                             zero_i,
  output logic                             valid_o,
  input  logic                             ready_i,
  output logic signed [chf_pkg::XyW-1:0]   a_o,
  output logic signed [chf_pkg::XyW-1:0]   b_o,
  output logic signed [ANG_W-1:0]          ang_o,
  output logic                             zero_o
);
  import chf_pkg::*;

  logic                    valid_q;
  logic signed [XyW-1:0]   a_q, a_d;
  logic signed [XyW-1:0]   b_q, b_d;
  logic signed [ANG_W-1:0] ang_q, ang_d;
  logic                    zero_q;
  logic signed [XyW-1:0]   da, db;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    da = b_i >>> STAGE;
    db = a_i >>> STAGE;
    if (b_i[XyW-1]) begin
      a_d   = a_i - da;
      b_d   = b_i + db;
      ang_d = ang_i - ATAN;
    end else begin
      a_d   = a_i + da;
      b_d   = b_i - db;
      ang_d = ang_i + ATAN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o) begin
      a_q    <= a_d;
      b_q    <= b_d;
      ang_q  <= ang_d;
      zero_q <= zero_i;
    end
  end

  assign valid_o = valid_q;
  assign a_o     = a_q;
  assign b_o     = b_q;
  assign ang_o   = ang_q;
  assign zero_o  = zero_q;

endmodule

>>> hw/rtl/chf_decl.sv
// declination register and its conversion from arcminutes to fixed-point degrees
module chf_decl #(
  parameter int unsigned ANG_W = 28,
  parameter int unsigned FRAC  = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic signed [chf_pkg::DeclW-1:0]  declination_arcmin_i,
  output logic signed [ANG_W-1:0]           decl_o
);
  import chf_pkg::*;

  logic signed [DeclW-1:0]    arcmin_q;
  logic [DeclW-1:0]           mag_d, mag_q;
  logic                       neg_q;
  logic [ProdW-1:0]           prod;
  logic [DeclQuoW-1:0]        k_q;
  logic [DeclW-1:0]           rem_full;
  logic [3:0]                 rem;
  logic [FRAC-3:0]            frac_lut [16];
  logic [DeclQuoW+FRAC-3:0]   quo;
  logic signed [ANG_W-1:0]    decl_d, decl_q;

  // arcmin * 2^FRAC / 60 = (15k + r) * 2^(FRAC-2) / 15
  for (genvar g = 0; g < 16; g++) begin : g_lut
    assign frac_lut[g] = (FRAC-2)'((64'(g) << (FRAC - 2)) / 15);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      arcmin_q <= DeclReset;
    end else if (cfg_we_i) begin
      arcmin_q <= declination_arcmin_i;
    end
  end

  always_comb begin
    mag_d    = arcmin_q[DeclW-1] ? DeclW'(-arcmin_q) : DeclW'(arcmin_q);
    prod     = ProdW'(mag_d) * ProdW'(Recip15);
    rem_full = mag_q - DeclW'({k_q, 4'b0000}) + DeclW'(k_q);
    rem      = rem_full[3:0];
    quo      = {k_q, frac_lut[rem]};
    decl_d   = neg_q ? -$signed(ANG_W'(quo)) : $signed(ANG_W'(quo));
  end

  always_ff @(posedge clk_i) begin
    mag_q  <= mag_d;
    neg_q  <= arcmin_q[DeclW-1];
    k_q    <= prod[RecipShift +: DeclQuoW];
    decl_q <= decl_d;
  end

  assign decl_o = decl_q;

endmodule

>>> hw/rtl/chf_post.sv
// declination add, wrap, clamp and output register
module chf_post #(
  parameter int unsigned ANG_W = 28,
  parameter int unsigned FRAC  = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  output logic                              ready_o,
  input  logic signed [ANG_W-1:0]           ang_i,
  input  logic                              zero_i,
  input  logic signed [ANG_W-1:0]           decl_i,
  output logic                              valid_o,
  input  logic                              ready_i,
  output logic [chf_pkg::HeadW-1:0]         heading_o
);
  import chf_pkg::*;

  localparam logic signed [ANG_W-1:0] Turn = ANG_W'(360) <<< FRAC;

  logic                    s1_valid_q, s2_valid_q;
  logic                    s1_rdy, s2_rdy;
  logic signed [ANG_W-1:0] sum_d, sum_q;
  logic signed [ANG_W-1:0] wrap, clip;
  logic [HeadW-1:0]        head_q;

  assign s2_rdy  = !s2_valid_q || ready_i;
  assign s1_rdy  = !s1_valid_q || s2_rdy;
  assign ready_o = s1_rdy;

  always_comb begin
    sum_d = (zero_i ? '0 : ang_i) + decl_i;
    if (sum_q < 0) begin
      wrap = sum_q + Turn;
    end else if (sum_q > Turn) begin
      wrap = sum_q - Turn;
    end else begin
      wrap = sum_q;
    end
    if (wrap < 0) begin
      clip = '0;
    end else if (wrap > Turn) begin
      clip = Turn;
    end else begin
      clip = wrap;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s1_rdy) begin
        s1_valid_q <= valid_i;
      end
      if (s2_rdy) begin
        s2_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_rdy) begin
      sum_q <= sum_d;
    end
    if (s2_rdy) begin
      head_q <= clip[FRAC +: HeadW];
    end
  end

  assign valid_o   = s2_valid_q;
  assign heading_o = head_q;

`ifndef SYNTHESIS
  a_ready_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ready_i |-> ready_o)
    else $error("ready lost with output free");
  a_head_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q |-> head_q <= HeadMax)
    else $error("heading above full turn");
  a_s1_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_i && ready_o) |=> s1_valid_q)
    else $error("request dropped at sum stage");
  a_s2_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s2_rdy) |=> s2_valid_q)
    else $error("request dropped at output stage");
`endif

endmodule

>>> hw/rtl/compass_heading_from_xy.sv
// compass heading top level: prescale, rotation cell chain, declination and wrap
// a request passes through each rotation cell register, then the sum and output registers
// throughput: one request per cycle while out_ready_i allows; each rotation cell and both output stages
//   hold one request and advance whenever the next stage has room
// reset: clears all stage valid bits and sets the declination to 266 arcmin;
//   the derived offset follows through the k_q and decl_q registers after reset or a write
module compass_heading_from_xy #(
  parameter int unsigned CORDIC_STAGES   = 16,
  parameter int unsigned ANGLE_FRAC_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic signed [chf_pkg::DeclW-1:0]  declination_arcmin_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [chf_pkg::FieldW-1:0] field_x_i,
  input  logic signed [chf_pkg::FieldW-1:0] field_y_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [chf_pkg::HeadW-1:0]         heading_degrees_o
);
  import chf_pkg::*;

  localparam int unsigned AngW = ANGLE_FRAC_BITS + 12;
  localparam logic signed [AngW-1:0] Half = AngW'(180) <<< ANGLE_FRAC_BITS;

  logic                   vld_w  [CORDIC_STAGES+1];
  logic                   rdy_w  [CORDIC_STAGES+1];
  logic signed [XyW-1:0]  a_w    [CORDIC_STAGES+1];
  logic signed [XyW-1:0]  b_w    [CORDIC_STAGES+1];
  logic signed [AngW-1:0] ang_w  [CORDIC_STAGES+1];
  logic                   zero_w [CORDIC_STAGES+1];
  logic signed [XyW-1:0]  x_ext, y_ext;
  logic signed [XyW-1:0]  a_in, b_in;
  logic signed [AngW-1:0] ang_in;
  logic                   zero_in;
  logic signed [AngW-1:0] decl;

  always_comb begin
    x_ext = $signed({{(XyW-FieldW-PrescaleW){field_x_i[FieldW-1]}}, field_x_i,
                     {PrescaleW{1'b0}}});
    y_ext = $signed({{(XyW-FieldW-PrescaleW){field_y_i[FieldW-1]}}, field_y_i,
                     {PrescaleW{1'b0}}});
    if (field_y_i[FieldW-1]) begin
      a_in   = -y_ext;
      b_in   = -x_ext;
      ang_in = field_x_i[FieldW-1] ? -Half : Half;
    end else begin
      a_in   = y_ext;
      b_in   = x_ext;
      ang_in = '0;
    end
    zero_in = (field_x_i == '0) && (field_y_i == '0);
  end

  assign a_w[0]     = a_in;
  assign b_w[0]     = b_in;
  assign ang_w[0]   = ang_in;
  assign zero_w[0]  = zero_in;
  assign vld_w[0]   = in_valid_i;
  assign in_ready_o = rdy_w[0];

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
    chf_cell #(
      .ANG_W (AngW),
      .STAGE (g),
      .ATAN  (AngW'(atan_deg(g, ANGLE_FRAC_BITS)))
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (vld_w[g]),
      .ready_o (rdy_w[g]),
      .a_i     (a_w[g]),
      .b_i     (b_w[g]),
      .ang_i   (ang_w[g]),
      .zero_i  (zero_w[g]),
      .valid_o (vld_w[g+1]),
      .ready_i (rdy_w[g+1]),
      .a_o     (a_w[g+1]),
      .b_o     (b_w[g+1]),
      .ang_o   (ang_w[g+1]),
      .zero_o  (zero_w[g+1])
    );
  end

  chf_decl #(
    .ANG_W (AngW),
    .FRAC  (ANGLE_FRAC_BITS)
  ) u_decl (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_we_i             (cfg_we_i),
    .declination_arcmin_i (declination_arcmin_i),
    .decl_o               (decl)
  );

  chf_post #(
    .ANG_W (AngW),
    .FRAC  (ANGLE_FRAC_BITS)
  ) u_post (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (vld_w[CORDIC_STAGES]),
    .ready_o   (rdy_w[CORDIC_STAGES]),
    .ang_i     (ang_w[CORDIC_STAGES]),
    .zero_i    (zero_w[CORDIC_STAGES]),
    .decl_i    (decl),
    .valid_o   (out_valid_o),
    .ready_i   (out_ready_i),
    .heading_o (heading_degrees_o)
  );

endmodule

>>> tb/sv/tb_compass_heading_from_xy.sv
// testbench for compass_heading_from_xy: random and directed x,y requests vs a predictor
`timescale 1ns / 100ps

module tb_compass_heading_from_xy;

  localparam int unsigned Stages   = 16;
  localparam int unsigned FracBits = 16;
  localparam longint      OneDeg   = longint'(1) <<< FracBits;
  localparam longint      FullTurn = 360 * OneDeg;
  localparam longint      RadToDeg = 64'sd246083499207;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned TailCycles = Stages + 12;

  typedef struct packed {
    logic signed [chf_pkg::FieldW-1:0] x;
    logic signed [chf_pkg::FieldW-1:0] y;
  } xy_req_t;

  logic                              clk_i = 1'b0;
  logic                              rst_ni = 1'b0;
  logic                              cfg_we_i = 1'b0;
  logic signed [chf_pkg::DeclW-1:0]  declination_arcmin_i = chf_pkg::DeclReset;
  logic                              in_valid_i = 1'b0;
  logic                              in_ready_o;
  logic signed [chf_pkg::FieldW-1:0] field_x_i = '0;
  logic signed [chf_pkg::FieldW-1:0] field_y_i = '0;
  logic                              out_valid_o;
  logic                              out_ready_i = 1'b0;
  logic [chf_pkg::HeadW-1:0]         heading_degrees_o;

  xy_req_t                           xy_pending[$];
  logic [chf_pkg::HeadW-1:0]         headings_due[$];
  logic signed [chf_pkg::DeclW-1:0]  decl_now = chf_pkg::DeclReset;
  longint                            step_deg[Stages];
  int unsigned                       gap_max = 19;
  int unsigned                       gap_left = 0;
  int unsigned                       stall_left = 0;
  int unsigned                       cycle_count = 0;
  int unsigned                       error_count = 0;
  bit                                req_taken = 1'b0;
  bit                                res_taken = 1'b0;

  compass_heading_from_xy #(
    .CORDIC_STAGES  (Stages),
    .ANGLE_FRAC_BITS(FracBits)
  ) i_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .declination_arcmin_i(declination_arcmin_i),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .field_x_i           (field_x_i),
    .field_y_i           (field_y_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .heading_degrees_o   (heading_degrees_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // atan(2^-i) in degrees, fixed point, rounded half up
  function automatic longint atan_step_q(input int unsigned i);
    longint      q32;
    longint      rad;
    longint      term;
    longint      hi;
    longint      lo;
    int unsigned e;
    rad = 0;
    if (i == 0) begin
      q32 = longint'(45) <<< 32;
    end else begin
      for (int unsigned n = 0; n < 64; n++) begin
        e = i * (2 * n + 1);
        if (e <= 40) begin
          term = (longint'(1) <<< (40 - e)) / longint'(2 * n + 1);
          if (n % 2 == 1) begin
            rad = rad - term;
          end else begin
            rad = rad + term;
          end
        end
      end
      hi  = rad >>> 20;
      lo  = rad & 64'hFFFFF;
      q32 = (hi * RadToDeg + ((lo * RadToDeg) >>> 20)) >>> 20;
    end
    return (q32 + (longint'(1) <<< (31 - FracBits))) >>> (32 - FracBits);
  endfunction

  function automatic longint cordic_angle(input logic signed [chf_pkg::FieldW-1:0] fx,
                                          input logic signed [chf_pkg::FieldW-1:0] fy);
    longint ha;
    longint vb;
    longint da;
    longint db;
    longint ang;
    ang = 0;
    if (fx != 0 || fy != 0) begin
      ha = longint'(fy) * 65536;
      vb = longint'(fx) * 65536;
      if (ha < 0) begin
        ang = (vb >= 0) ? 180 * OneDeg : -180 * OneDeg;
        ha  = -ha;
        vb  = -vb;
      end
      for (int unsigned k = 0; k < Stages; k++) begin
        da = vb >>> k;
        db = ha >>> k;
        if (vb >= 0) begin
          ha  = ha + da;
          vb  = vb - db;
          ang = ang + step_deg[k];
        end else begin
          ha  = ha - da;
          vb  = vb + db;
          ang = ang - step_deg[k];
        end
      end
    end
    return ang;
  endfunction

  function automatic logic [chf_pkg::HeadW-1:0] predict_heading(
      input logic signed [chf_pkg::FieldW-1:0] fx,
      input logic signed [chf_pkg::FieldW-1:0] fy,
      input logic signed [chf_pkg::DeclW-1:0]  decl);
    longint ang;
    ang = cordic_angle(fx, fy) + (longint'(decl) * OneDeg) / 60;
    if (ang < 0) begin
      ang = ang + FullTurn;
    end else if (ang > FullTurn) begin
      ang = ang - FullTurn;
    end
    if (ang < 0) begin
      ang = 0;
    end
    if (ang > FullTurn) begin
      ang = FullTurn;
    end
    return chf_pkg::HeadW'(ang >>> FracBits);
  endfunction

  function automatic int unsigned draw_wait();
    return $urandom_range(0, gap_max);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    error_count++;
  endtask

  task automatic push_xy(input int fx, input int fy);
    xy_req_t r;
    r.x = fx[chf_pkg::FieldW-1:0];
    r.y = fy[chf_pkg::FieldW-1:0];
    xy_pending.push_back(r);
  endtask

  task automatic wait_drained();
    while (xy_pending.size() != 0 || in_valid_i || headings_due.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  task automatic write_declination(input logic signed [chf_pkg::DeclW-1:0] v);
    @(negedge clk_i);
    cfg_we_i             <= 1'b1;
    declination_arcmin_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    decl_now = v;
    // derived offset lags the register through the k_q and decl_q registers
    repeat (4) @(negedge clk_i);
  endtask

  // request side
  always @(negedge clk_i) begin
    xy_req_t r;
    if (rst_ni && !(in_valid_i && !req_taken)) begin
      if (in_valid_i) begin
        gap_left = draw_wait();
      end
      if (gap_left == 0 && xy_pending.size() != 0) begin
        r = xy_pending.pop_front();
        field_x_i  <= r.x;
        field_y_i  <= r.y;
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
        if (gap_left != 0) begin
          gap_left--;
        end
      end
    end
  end

  // result side
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_ready_i && res_taken) begin
        stall_left = draw_wait();
      end
      if (stall_left == 0) begin
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b0;
        stall_left--;
      end
    end
  end

  always @(posedge clk_i) begin
    logic [chf_pkg::HeadW-1:0] want;
    cycle_count++;
    req_taken = rst_ni && in_valid_i && in_ready_o;
    res_taken = rst_ni && out_valid_o && out_ready_i;
    if (req_taken) begin
      headings_due.push_back(predict_heading(field_x_i, field_y_i, decl_now));
    end
    if (res_taken) begin
      if (headings_due.size() == 0) begin
        report_mismatch($sformatf("heading %0d with no request pending", heading_degrees_o));
      end else begin
        want = headings_due.pop_front();
        if (heading_degrees_o !== want) begin
          report_mismatch($sformatf("heading_degrees got %0d want %0d",
                                    heading_degrees_o, want));
        end
      end
    end
    if (cycle_count >= CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    logic signed [chf_pkg::DeclW-1:0]  decl_list[10];
    logic signed [chf_pkg::FieldW-1:0] turn_x;
    logic signed [chf_pkg::FieldW-1:0] turn_y;
    logic signed [chf_pkg::DeclW-1:0]  turn_decl;
    bit                                turn_found;
    longint                            ang;
    int                                fx;
    int                                fy;
    int unsigned                       mode;

    for (int unsigned k = 0; k < Stages; k++) begin
      step_deg[k] = atan_step_q(k);
    end

    // look for a request whose angle plus some declination lands on a full turn
    turn_found = 1'b0;
    turn_x     = '0;
    turn_y     = '0;
    turn_decl  = '0;
    for (int t = 0; t < 200000 && !turn_found; t++) begin
      fx  = $urandom_range(1, 32767);
      fy  = -int'($urandom_range(1, 32768));
      ang = cordic_angle(fx[15:0], fy[15:0]);
      if (ang % 16384 == 0 && ang >= 88 * OneDeg) begin
        turn_found = 1'b1;
        turn_x     = fx[15:0];
        turn_y     = fy[15:0];
        turn_decl  = chf_pkg::DeclW'(15 * ((FullTurn - ang) / 16384));
      end
    end

    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (4) @(negedge clk_i);

    // directed requests at the reset declination
    gap_max = 3;
    push_xy(0, 0);
    push_xy(32767, 0);
    push_xy(-32768, 0);
    push_xy(0, 32767);
    push_xy(0, -32768);
    push_xy(32767, 32767);
    push_xy(-32768, -32768);
    push_xy(32767, -32768);
    push_xy(-32768, 32767);
    push_xy(1, 0);
    push_xy(-1, 0);
    push_xy(0, 1);
    push_xy(0, -1);
    push_xy(1, -1);
    push_xy(-1, -1);
    push_xy(-1, -32768);
    push_xy(-1, 1);
    push_xy(1, 1);
    push_xy(-21846, 21845);
    push_xy(255, -256);
    wait_drained();

    if (turn_found) begin
      write_declination(turn_decl);
      push_xy(turn_x, turn_y);
      push_xy(0, 0);
      wait_drained();
    end

    decl_list[0] = 15'sd0;
    decl_list[1] = 15'sd10800;
    decl_list[2] = -15'sd10800;
    decl_list[3] = 15'sd16383;
    decl_list[4] = -15'sd16384;
    decl_list[5] = 15'sd266;
    for (int p = 6; p < 10; p++) begin
      decl_list[p] = chf_pkg::DeclW'($urandom());
    end

    for (int p = 0; p < 10; p++) begin
      write_declination(decl_list[p]);
      case (p % 3)
        0: gap_max = 19;
        1: gap_max = 0;
        default: gap_max = 4;
      endcase
      for (int n = 0; n < 75; n++) begin
        mode = $urandom_range(0, 9);
        if (mode < 6) begin
          fx = $urandom();
          fy = $urandom();
        end else if (mode < 8) begin
          fx = int'($urandom_range(0, 64)) - 32;
          fy = int'($urandom_range(0, 64)) - 32;
        end else if (mode == 8) begin
          fx = $urandom_range(0, 1) ? 0 : $urandom();
          fy = (fx == 0) ? $urandom() : 0;
        end else begin
          fx = $urandom_range(0, 1) ? 32767 : -32768;
          fy = $urandom_range(0, 1) ? 32767 : -32768;
        end
        push_xy(fx, fy);
      end
      wait_drained();
    end

    repeat (TailCycles) @(negedge clk_i);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/chf_pkg.sv
hw/rtl/chf_cell.sv
hw/rtl/chf_decl.sv
hw/rtl/chf_post.sv
hw/rtl/compass_heading_from_xy.sv
tb/sv/tb_compass_heading_from_xy.sv
